### sv/nfmr_pkg.sv
// shared constants, codes and helpers for the nibble fifo message reader
package nfmr_pkg;

  localparam int FIFO_DEPTH = 4096;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = 12;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    ACT_NIBBLE = 2'd0,
    ACT_READ   = 2'd1,
    ACT_OPEN   = 2'd2,
    ACT_CLOSE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_BYTE     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_MSG_END  = 3'd3,
    ST_OVER     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_READ    = 4'b0010,
    S_CL_ADDR = 4'b0100,
    S_CL_DATA = 4'b1000
  } state_t;

  localparam ptr_t PTR_LAST = ptr_t'(FIFO_DEPTH - 1);

  // circular increment, wraps at the depth
  function automatic ptr_t advance(input ptr_t p);
    advance = (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // bytes held between the pointers, low bits only
  function automatic logic [CNT_W-1:0] fill_count(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] diff;
    diff = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                      : ({1'b0, wp} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, rp});
    fill_count = CNT_W'(diff);
  endfunction

endpackage

### sv/nibble_fifo_message_reader.sv
// nibble pair assembler with circular byte fifo and session reader
//
// one transaction is taken when start is high and busy is low; its result
// is shown for exactly one cycle with done high, and the receiver cannot
// stall it. nibble, open and close-after-session-end transactions, and reads
// that find the fifo empty or the session over, keep busy low and report in
// the next cycle, so one may be issued every cycle. a read that pops a byte
// holds busy high in S_READ because the byte store is a synchronous ram with
// registered read data. a close walks the store through that single read port,
// alternating S_CL_ADDR and S_CL_DATA per byte, until the fifo runs dry or a nul
// ends the walk as the last discarded byte. the store needs no clearing after reset.
module nibble_fifo_message_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [3:0]  nibble,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [11:0] fill_level,
  output logic        overflow,
  output logic [11:0] discarded
);

  // control state
  nfmr_pkg::state_t state;
  nfmr_pkg::ptr_t   write_pointer;
  nfmr_pkg::ptr_t   read_pointer;
  logic             nibble_pending;
  logic [3:0]       high_nibble;
  logic             session_over;
  logic [nfmr_pkg::CNT_W-1:0] drop_count;

  // byte store, one write and one read port
  logic [7:0] byte_store [nfmr_pkg::FIFO_DEPTH];
  logic [7:0] rd_data;
  logic       rd_en;
  logic       wr_en;

  logic           accept;
  logic           fifo_empty;
  nfmr_pkg::ptr_t wp_adv;

  assign busy       = (state != nfmr_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign fifo_empty = (write_pointer == read_pointer);
  assign wp_adv     = nfmr_pkg::advance(write_pointer);

  // the second nibble of a pair writes unless the store is full
  assign wr_en = accept && (action == nfmr_pkg::ACT_NIBBLE) && nibble_pending &&
                 (wp_adv != read_pointer);

  // reads always come from the head of the fifo
  assign rd_en = (accept && (action == nfmr_pkg::ACT_READ) && !session_over && !fifo_empty) ||
                 ((state == nfmr_pkg::S_CL_ADDR) && !fifo_empty);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[write_pointer] <= {high_nibble, nibble};
    end
    if (rd_en) begin
      rd_data <= byte_store[read_pointer];
    end
  end

  // fill level follows the pointers, already updated when done is high
  assign fill_level = nfmr_pkg::fill_count(write_pointer, read_pointer);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= nfmr_pkg::S_IDLE;
      write_pointer  <= '0;
      read_pointer   <= '0;
      nibble_pending <= 1'b0;
      high_nibble    <= '0;
      session_over   <= 1'b0;
      drop_count     <= '0;
      done           <= 1'b0;
      status         <= nfmr_pkg::ST_ACCEPTED;
      data_byte      <= '0;
      overflow       <= 1'b0;
      discarded      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        nfmr_pkg::S_IDLE: begin
          if (accept) begin
            // default result for the single-cycle transactions
            done      <= 1'b1;
            status    <= nfmr_pkg::ST_ACCEPTED;
            data_byte <= '0;
            overflow  <= 1'b0;
            discarded <= '0;
            unique case (nfmr_pkg::action_t'(action))
              nfmr_pkg::ACT_NIBBLE: begin
                if (!nibble_pending) begin
                  high_nibble    <= nibble;
                  nibble_pending <= 1'b1;
                end else begin
                  // pair finishes even when the byte is dropped
                  nibble_pending <= 1'b0;
                  if (wp_adv != read_pointer) begin
                    write_pointer <= wp_adv;
                  end else begin
                    overflow <= 1'b1;
                  end
                end
              end
              nfmr_pkg::ACT_READ: begin
                if (session_over) begin
                  status <= nfmr_pkg::ST_OVER;
                end else if (fifo_empty) begin
                  status <= nfmr_pkg::ST_EMPTY;
                end else begin
                  // wait for the store to return the head byte
                  done  <= 1'b0;
                  state <= nfmr_pkg::S_READ;
                end
              end
              nfmr_pkg::ACT_OPEN: begin
                session_over <= 1'b0;
              end
              nfmr_pkg::ACT_CLOSE: begin
                if (!session_over) begin
                  done       <= 1'b0;
                  drop_count <= '0;
                  state      <= nfmr_pkg::S_CL_ADDR;
                end
              end
              default: ;
            endcase
          end
        end
        nfmr_pkg::S_READ: begin
          done         <= 1'b1;
          overflow     <= 1'b0;
          discarded    <= '0;
          read_pointer <= nfmr_pkg::advance(read_pointer);
          if (rd_data == 8'h00) begin
            // nul ends the session and is not handed out
            session_over <= 1'b1;
            status       <= nfmr_pkg::ST_MSG_END;
            data_byte    <= '0;
          end else begin
            status    <= nfmr_pkg::ST_BYTE;
            data_byte <= rd_data;
          end
          state <= nfmr_pkg::S_IDLE;
        end
        nfmr_pkg::S_CL_ADDR: begin
          // read of the head was issued here unless the fifo ran dry
          if (fifo_empty) begin
            done      <= 1'b1;
            status    <= nfmr_pkg::ST_ACCEPTED;
            data_byte <= '0;
            overflow  <= 1'b0;
            discarded <= drop_count;
            state     <= nfmr_pkg::S_IDLE;
          end else begin
            state <= nfmr_pkg::S_CL_DATA;
          end
        end
        nfmr_pkg::S_CL_DATA: begin
          read_pointer <= nfmr_pkg::advance(read_pointer);
          drop_count   <= drop_count + 1'b1;
          if (rd_data == 8'h00) begin
            // discard stops after the first nul
            done      <= 1'b1;
            status    <= nfmr_pkg::ST_ACCEPTED;
            data_byte <= '0;
            overflow  <= 1'b0;
            discarded <= drop_count + 1'b1;
            state     <= nfmr_pkg::S_IDLE;
          end else begin
            state <= nfmr_pkg::S_CL_ADDR;
          end
        end
        default: begin
          state <= nfmr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // nothing is written to the store while a read or close is in progress
  a_wp_stable_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(write_pointer))
    else $error("write pointer moved during a multi-cycle transaction");

  // entering a multi-cycle transaction never shows a result in the same cycle
  a_no_done_on_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !done)
    else $error("result strobe raised as busy rose");

  // only a plain accepted transaction can report an overflow or a discard
  a_ovf_disc_status: assert property (@(posedge clk) disable iff (rst)
    done && (overflow || (discarded != '0)) |-> (status == nfmr_pkg::ST_ACCEPTED))
    else $error("overflow or discard reported with the wrong status");

  // a byte is returned only with the byte status
  a_data_only_byte: assert property (@(posedge clk) disable iff (rst)
    done && (data_byte != '0) |-> (status == nfmr_pkg::ST_BYTE))
    else $error("data byte set on a result that returns no byte");

endmodule
